[sv/lqls_pkg.sv]
// Shared types, register indexes, status and lane codes for the lane selector.
package lqls_pkg;

    localparam int CLIENT_SLOTS_DEF = 16;
    localparam int RTT_WINDOW_DEF   = 10;

    localparam int RTT_W   = 23;
    localparam int RUN_W   = 8;
    localparam int TIME_W  = 40;
    localparam int PID_W   = 31;
    localparam int PADDR_W = 5;

    localparam logic [2:0] REG_SLOW_LIMIT   = 3'd0;
    localparam logic [2:0] REG_SWING_LIMIT  = 3'd1;
    localparam logic [2:0] REG_STREAK_LIMIT = 3'd2;
    localparam logic [2:0] REG_COOLDOWN_MS  = 3'd3;
    localparam logic [2:0] REG_PORT_GREEN   = 3'd4;
    localparam logic [2:0] REG_PORT_YELLOW  = 3'd5;
    localparam logic [2:0] REG_PORT_RED     = 3'd6;

    localparam logic [2:0] ST_REGISTERED = 3'd0;
    localparam logic [2:0] ST_FULL       = 3'd1;
    localparam logic [2:0] ST_UNKNOWN    = 3'd2;
    localparam logic [2:0] ST_KEPT       = 3'd3;
    localparam logic [2:0] ST_SWITCHED   = 3'd4;

    localparam logic [1:0] LN_GREEN  = 2'd0;
    localparam logic [1:0] LN_YELLOW = 2'd1;
    localparam logic [1:0] LN_RED    = 2'd2;

    localparam logic OP_REGISTER = 1'b0;
    localparam logic OP_METRIC   = 1'b1;

    typedef struct packed {
        logic [RTT_W-1:0] slow_limit;
        logic [RTT_W-1:0] swing_limit;
        logic [7:0]       streak_limit;
        logic [31:0]      cooldown_ms;
        logic [15:0]      port_green;
        logic [15:0]      port_yellow;
        logic [15:0]      port_red;
    } t_cfg;

    typedef struct packed {
        logic [2:0]       status;
        logic [3:0]       slot;
        logic [PID_W-1:0] client_pid;
        logic [1:0]       lane;
        logic [15:0]      lane_port;
        logic [31:0]      dest_ip;
        logic [15:0]      dest_port;
        logic [RUN_W-1:0] loss_run;
        logic [RUN_W-1:0] slow_run;
        logic [RUN_W-1:0] swing_run;
    } t_res;

    // Saturating streak step: a miss clears the streak.
    function automatic logic [RUN_W-1:0] bump(input logic [RUN_W-1:0] run, input logic hit);
        logic [RUN_W-1:0] v;
        v = '0;
        if (hit) begin
            v = (run == '1) ? run : run + 1'b1;
        end
        return v;
    endfunction

endpackage

[sv/lqls_if.sv]
// Valid/ready channel interfaces for input items and result items.
interface lqls_in_if;
    logic                      valid;
    logic                      ready;
    logic                      opcode;
    logic [30:0]               client_id;
    logic signed [23:0]        rtt_sample;
    logic                      loss_seen;
    logic [39:0]               now_ms;
    logic [31:0]               peer_ip;
    logic [15:0]               peer_port;
    modport source (output valid, opcode, client_id, rtt_sample, loss_seen, now_ms,
                    peer_ip, peer_port, input ready);
    modport sink (input valid, opcode, client_id, rtt_sample, loss_seen, now_ms,
                  peer_ip, peer_port, output ready);
endinterface

interface lqls_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [30:0] client_pid;
    logic [1:0]  lane;
    logic [15:0] lane_port;
    logic [31:0] dest_ip;
    logic [15:0] dest_port;
    logic [7:0]  loss_run;
    logic [7:0]  slow_run;
    logic [7:0]  swing_run;
    modport source (output valid, status, slot, client_pid, lane, lane_port, dest_ip,
                    dest_port, loss_run, slow_run, swing_run, input ready);
    modport sink (input valid, status, slot, client_pid, lane, lane_port, dest_ip,
                  dest_port, loss_run, slow_run, swing_run, output ready);
endinterface

[sv/lqls_cfg.sv]
// APB configuration register file for the lane selector.
module lqls_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [lqls_pkg::PADDR_W-1:0]    i_paddr,
    input  logic [31:0]                     i_pwdata,
    output logic [31:0]                     o_prdata,
    output logic                            o_pready,
    output lqls_pkg::t_cfg                  o_cfg
);

    lqls_pkg::t_cfg r_cfg;
    logic [2:0]     idx;
    logic           wr;

    assign idx      = i_paddr[4:2];
    assign wr       = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slow_limit   <= 23'd1600;
            r_cfg.swing_limit  <= 23'd320;
            r_cfg.streak_limit <= 8'd3;
            r_cfg.cooldown_ms  <= 32'd10000;
            r_cfg.port_green   <= 16'd5000;
            r_cfg.port_yellow  <= 16'd6000;
            r_cfg.port_red     <= 16'd7000;
        end else if (wr) begin
            unique case (idx)
                lqls_pkg::REG_SLOW_LIMIT:   r_cfg.slow_limit   <= i_pwdata[22:0];
                lqls_pkg::REG_SWING_LIMIT:  r_cfg.swing_limit  <= i_pwdata[22:0];
                lqls_pkg::REG_STREAK_LIMIT: r_cfg.streak_limit <= i_pwdata[7:0];
                lqls_pkg::REG_COOLDOWN_MS:  r_cfg.cooldown_ms  <= i_pwdata;
                lqls_pkg::REG_PORT_GREEN:   r_cfg.port_green   <= i_pwdata[15:0];
                lqls_pkg::REG_PORT_YELLOW:  r_cfg.port_yellow  <= i_pwdata[15:0];
                lqls_pkg::REG_PORT_RED:     r_cfg.port_red     <= i_pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            lqls_pkg::REG_SLOW_LIMIT:   o_prdata = {9'd0, r_cfg.slow_limit};
            lqls_pkg::REG_SWING_LIMIT:  o_prdata = {9'd0, r_cfg.swing_limit};
            lqls_pkg::REG_STREAK_LIMIT: o_prdata = {24'd0, r_cfg.streak_limit};
            lqls_pkg::REG_COOLDOWN_MS:  o_prdata = r_cfg.cooldown_ms;
            lqls_pkg::REG_PORT_GREEN:   o_prdata = {16'd0, r_cfg.port_green};
            lqls_pkg::REG_PORT_YELLOW:  o_prdata = {16'd0, r_cfg.port_yellow};
            lqls_pkg::REG_PORT_RED:     o_prdata = {16'd0, r_cfg.port_red};
            default:                    o_prdata = '0;
        endcase
    end

endmodule

[sv/lqls_core.sv]
// Sequencer, client and RTT memories and the shared comparator of the lane selector.
module lqls_core #(
    parameter int CLIENT_SLOTS = lqls_pkg::CLIENT_SLOTS_DEF,
    parameter int RTT_WINDOW   = lqls_pkg::RTT_WINDOW_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lqls_pkg::t_cfg i_cfg,
    lqls_in_if.sink        i_in,
    lqls_out_if.source     o_out
);

    localparam int SLOT_W  = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
    localparam int TOTAL_W = $clog2(CLIENT_SLOTS + 1);
    localparam int POS_W   = (RTT_WINDOW > 1) ? $clog2(RTT_WINDOW) : 1;
    localparam int FILL_W  = $clog2(RTT_WINDOW + 1);
    localparam int RING_N  = CLIENT_SLOTS * RTT_WINDOW;
    localparam int RING_AW = (RING_N > 1) ? $clog2(RING_N) : 1;
    localparam int RTT_W   = lqls_pkg::RTT_W;
    localparam int RUN_W   = lqls_pkg::RUN_W;
    localparam int TIME_W  = lqls_pkg::TIME_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_CMP  = 4'd2;
    localparam logic [3:0] S_UPD  = 4'd3;
    localparam logic [3:0] S_MR   = 4'd4;
    localparam logic [3:0] S_MN   = 4'd5;
    localparam logic [3:0] S_MX   = 4'd6;
    localparam logic [3:0] S_SW   = 4'd7;
    localparam logic [3:0] S_CD   = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    typedef struct packed {
        logic [lqls_pkg::PID_W-1:0] pid;
        logic [31:0]                ip;
        logic [15:0]                port;
        logic [1:0]                 lane;
        logic [FILL_W-1:0]          fill;
        logic [POS_W-1:0]           pos;
        logic [RUN_W-1:0]           loss;
        logic [RUN_W-1:0]           slow;
        logic [RUN_W-1:0]           swing;
        logic [TIME_W-1:0]          cd_end;
    } t_rec;

    t_rec             r_mem [CLIENT_SLOTS];
    logic [RTT_W-1:0] r_ring [RING_N];

    logic [3:0]                 r_state;
    logic [TOTAL_W-1:0]         r_total;
    logic [SLOT_W-1:0]          r_k;
    logic [RING_AW-1:0]         r_base;
    logic [POS_W-1:0]           r_j;
    logic [lqls_pkg::PID_W-1:0] r_pid;
    logic [RTT_W-1:0]           r_rtt;
    logic                       r_loss_in;
    logic [TIME_W-1:0]          r_now;
    t_rec                       r_rec_q;
    t_rec                       r_cur;
    logic [RTT_W-1:0]           r_ring_q;
    logic [RTT_W-1:0]           r_mn;
    logic [RTT_W-1:0]           r_mx;
    logic [1:0]                 r_des;
    lqls_pkg::t_res             r_res;
    lqls_pkg::t_res             r_out;
    logic                       r_ovalid;

    logic               mem_we;
    logic [SLOT_W-1:0]  mem_wa;
    t_rec               mem_wd;
    logic               ring_we;
    logic [RING_AW-1:0] ring_wa;
    logic [RING_AW-1:0] ring_ra;

    logic [TIME_W-1:0] cmp_a;
    logic [TIME_W-1:0] cmp_b;
    logic              cmp_gt;

    logic [POS_W-1:0]  upd_pos;
    t_rec              upd_rec;
    lqls_pkg::t_res    idle_res;
    logic [RUN_W-1:0]  new_swing;
    logic [1:0]        trig;
    logic [TIME_W:0]   cd_sum;
    logic [TIME_W-1:0] cd_new;
    logic              do_switch;
    logic [1:0]        fin_lane;
    logic [15:0]       fin_port;
    logic              last_slot;
    logic              last_entry;
    logic              in_acc;

    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign ring_ra    = r_base + RING_AW'(r_j);
    assign last_slot  = (TOTAL_W'(r_k) + 1'b1) == r_total;
    assign last_entry = (FILL_W'(r_j) + 1'b1) == r_cur.fill;
    assign upd_pos    = (FILL_W'(r_rec_q.pos) < FILL_W'(RTT_WINDOW)) ? r_rec_q.pos : '0;

    // One magnitude comparator serves the slow, min, max, swing and cooldown tests of the item.
    always_comb begin
        case (r_state)
            S_UPD: begin
                cmp_a = TIME_W'(r_rtt);
                cmp_b = TIME_W'(i_cfg.slow_limit);
            end
            S_MN: begin
                cmp_a = TIME_W'(r_mn);
                cmp_b = TIME_W'(r_ring_q);
            end
            S_MX: begin
                cmp_a = TIME_W'(r_ring_q);
                cmp_b = TIME_W'(r_mx);
            end
            S_SW: begin
                cmp_a = TIME_W'(r_mx - r_mn);
                cmp_b = TIME_W'(i_cfg.swing_limit);
            end
            S_CD: begin
                cmp_a = r_cur.cd_end;
                cmp_b = r_now;
            end
            default: begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
        cmp_gt = cmp_a > cmp_b;
    end

    // Result of an item that is settled at acceptance: register, full table or unknown.
    always_comb begin
        idle_res            = '0;
        idle_res.client_pid = i_in.client_id;
        if (i_in.opcode == lqls_pkg::OP_REGISTER) begin
            if (r_total == TOTAL_W'(CLIENT_SLOTS)) begin
                idle_res.status = lqls_pkg::ST_FULL;
            end else begin
                idle_res.status    = lqls_pkg::ST_REGISTERED;
                idle_res.slot      = 4'(r_total[SLOT_W-1:0]);
                idle_res.lane      = lqls_pkg::LN_GREEN;
                idle_res.lane_port = i_cfg.port_green;
                idle_res.dest_ip   = i_in.peer_ip;
                idle_res.dest_port = i_in.peer_port;
            end
        end else begin
            idle_res.status = lqls_pkg::ST_UNKNOWN;
        end
    end

    always_comb begin
        upd_rec      = r_rec_q;
        upd_rec.fill = (r_rec_q.fill < FILL_W'(RTT_WINDOW)) ? r_rec_q.fill + 1'b1
                                                             : r_rec_q.fill;
        upd_rec.pos  = (FILL_W'(upd_pos) == FILL_W'(RTT_WINDOW - 1)) ? '0 : upd_pos + 1'b1;
        upd_rec.loss = lqls_pkg::bump(r_rec_q.loss, r_loss_in);
        upd_rec.slow = lqls_pkg::bump(r_rec_q.slow, cmp_gt);
    end

    always_comb begin
        new_swing = lqls_pkg::bump(r_cur.swing, cmp_gt);
        trig = 2'(r_cur.loss >= i_cfg.streak_limit) + 2'(r_cur.slow >= i_cfg.streak_limit)
             + 2'(new_swing >= i_cfg.streak_limit);
        cd_sum    = {1'b0, r_now} + (TIME_W + 1)'(i_cfg.cooldown_ms);
        cd_new    = cd_sum[TIME_W] ? '1 : cd_sum[TIME_W-1:0];
        do_switch = (r_des != r_cur.lane) && !cmp_gt;
        fin_lane  = do_switch ? r_des : r_cur.lane;
        case (fin_lane)
            lqls_pkg::LN_YELLOW: fin_port = i_cfg.port_yellow;
            lqls_pkg::LN_RED:    fin_port = i_cfg.port_red;
            default:             fin_port = i_cfg.port_green;
        endcase
    end

    always_comb begin
        mem_we  = 1'b0;
        mem_wa  = r_k;
        mem_wd  = r_cur;
        ring_we = (r_state == S_UPD);
        ring_wa = r_base + RING_AW'(upd_pos);
        if (r_state == S_IDLE) begin
            mem_we = in_acc && (i_in.opcode == lqls_pkg::OP_REGISTER)
                     && (r_total != TOTAL_W'(CLIENT_SLOTS));
            mem_wa = r_total[SLOT_W-1:0];
            mem_wd = '{pid: i_in.client_id, ip: i_in.peer_ip, port: i_in.peer_port,
                       lane: lqls_pkg::LN_GREEN, fill: '0, pos: '0, loss: '0,
                       slow: '0, swing: '0, cd_end: '0};
        end else if (r_state == S_CD) begin
            mem_we        = 1'b1;
            mem_wd.lane   = fin_lane;
            mem_wd.cd_end = do_switch ? cd_new : r_cur.cd_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rec_q <= r_mem[r_k];
        if (ring_we) begin
            r_ring[ring_wa] <= r_rtt;
        end
        r_ring_q <= r_ring[ring_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_total  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_OUT && (!r_ovalid || o_out.ready)) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in.opcode == lqls_pkg::OP_METRIC && r_total != '0) begin
                            r_state <= S_RD;
                        end else begin
                            r_state <= S_OUT;
                        end
                        if (i_in.opcode == lqls_pkg::OP_REGISTER
                            && r_total != TOTAL_W'(CLIENT_SLOTS)) begin
                            r_total <= r_total + 1'b1;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_rec_q.pid == r_pid) begin
                        r_state <= S_UPD;
                    end else if (last_slot) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_UPD: begin
                    r_state <= S_MR;
                end
                S_MR: begin
                    r_state <= S_MN;
                end
                S_MN: begin
                    if (r_j != '0) begin
                        r_state <= S_MX;
                    end else if (last_entry) begin
                        r_state <= S_SW;
                    end else begin
                        r_state <= S_MR;
                    end
                end
                S_MX: begin
                    r_state <= last_entry ? S_SW : S_MR;
                end
                S_SW: begin
                    r_state <= S_CD;
                end
                S_CD: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers; these need no reset.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_k       <= '0;
                r_base    <= '0;
                r_pid     <= i_in.client_id;
                r_rtt     <= i_in.rtt_sample[23] ? '0 : i_in.rtt_sample[22:0];
                r_loss_in <= i_in.loss_seen;
                r_now     <= i_in.now_ms;
                r_res     <= idle_res;
            end
            S_CMP: begin
                if (r_rec_q.pid != r_pid) begin
                    r_k    <= r_k + 1'b1;
                    r_base <= r_base + RING_AW'(RTT_WINDOW);
                end
            end
            S_UPD: begin
                r_cur <= upd_rec;
                r_j   <= '0;
            end
            S_MN: begin
                if (r_j == '0) begin
                    r_mn <= r_ring_q;
                    r_mx <= r_ring_q;
                    if (!last_entry) begin
                        r_j <= r_j + 1'b1;
                    end
                end else if (cmp_gt) begin
                    r_mn <= r_ring_q;
                end
            end
            S_MX: begin
                if (cmp_gt) begin
                    r_mx <= r_ring_q;
                end
                if (!last_entry) begin
                    r_j <= r_j + 1'b1;
                end
            end
            S_SW: begin
                r_cur.swing <= new_swing;
                r_des <= (trig >= 2'd2) ? lqls_pkg::LN_RED
                       : (trig == 2'd1) ? lqls_pkg::LN_YELLOW : lqls_pkg::LN_GREEN;
            end
            S_CD: begin
                r_res.status     <= do_switch ? lqls_pkg::ST_SWITCHED : lqls_pkg::ST_KEPT;
                r_res.slot       <= 4'(r_k);
                r_res.client_pid <= r_cur.pid;
                r_res.lane       <= fin_lane;
                r_res.lane_port  <= fin_port;
                r_res.dest_ip    <= r_cur.ip;
                r_res.dest_port  <= r_cur.port;
                r_res.loss_run   <= r_cur.loss;
                r_res.slow_run   <= r_cur.slow;
                r_res.swing_run  <= r_cur.swing;
            end
            S_OUT: begin
                if (!r_ovalid || o_out.ready) begin
                    r_out <= r_res;
                end
            end
            default: ;
        endcase
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.status     = r_out.status;
    assign o_out.slot       = r_out.slot;
    assign o_out.client_pid = r_out.client_pid;
    assign o_out.lane       = r_out.lane;
    assign o_out.lane_port  = r_out.lane_port;
    assign o_out.dest_ip    = r_out.dest_ip;
    assign o_out.dest_port  = r_out.dest_port;
    assign o_out.loss_run   = r_out.loss_run;
    assign o_out.slow_run   = r_out.slow_run;
    assign o_out.swing_run  = r_out.swing_run;

endmodule

[sv/link_quality_lane_selector_unit.sv]
// Top level of the link quality lane selector: APB registers and the sequenced core.
// Register items and a full table are settled at acceptance and go straight to the output state.
// A metric item searches the table one slot at a time (read, compare), then writes the ring
// and walks the filled window entries for min/max, then tests the swing and the cooldown.
// One item at a time; the single record read port and shared comparator set the pace.
// Synchronous active-low reset empties the table and restores register defaults.
module link_quality_lane_selector_unit #(
    parameter int CLIENT_SLOTS = lqls_pkg::CLIENT_SLOTS_DEF,
    parameter int RTT_WINDOW   = lqls_pkg::RTT_WINDOW_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    lqls_in_if.sink                      i_in,
    lqls_out_if.source                   o_out,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [lqls_pkg::PADDR_W-1:0] i_paddr,
    input  logic [31:0]                  i_pwdata,
    output logic [31:0]                  o_prdata,
    output logic                         o_pready
);

    lqls_pkg::t_cfg cfg;

    lqls_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (cfg)
    );

    lqls_core #(
        .CLIENT_SLOTS (CLIENT_SLOTS),
        .RTT_WINDOW   (RTT_WINDOW)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

[sv/lqls_check.sv]
// Port-level checker for the lane selector and its bind to the top level.
module lqls_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  out_status,
    input logic [3:0]  out_slot,
    input logic [1:0]  out_lane,
    input logic [15:0] out_lane_port
);

    // One item at a time: the input closes for the cycle after a beat.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after an accepted beat");

    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result beat valid right after reset");

    a_reject_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && (out_status == lqls_pkg::ST_FULL || out_status == lqls_pkg::ST_UNKNOWN))
        |-> (out_slot == 4'd0 && out_lane == lqls_pkg::LN_GREEN && out_lane_port == 16'd0))
        else $error("rejected item carries slot or lane data");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_status) && $stable(out_slot)))
        else $error("stalled result beat changed");

endmodule

bind link_quality_lane_selector_unit lqls_check u_lqls_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .in_valid      (i_in.valid),
    .in_ready      (i_in.ready),
    .out_valid     (o_out.valid),
    .out_ready     (o_out.ready),
    .out_status    (o_out.status),
    .out_slot      (o_out.slot),
    .out_lane      (o_out.lane),
    .out_lane_port (o_out.lane_port)
);
